// ----- design/bpgd_pkg.sv -----
// Package for the button press gesture decoder.
// Holds the shared types, register indexes and reset values. No dependencies.
`default_nettype none

package bpgd_pkg;

   localparam int NOW_W     = 32;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PRESS_MAX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PANIC_HOLD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_HOLD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MENU_LONG_HOLD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MENU_SETUP_HOLD = 3'd4;

   localparam logic [CFG_W-1:0] RST_SHORT_PRESS_MAX = 16'd800;
   localparam logic [CFG_W-1:0] RST_PANIC_HOLD      = 16'd1000;
   localparam logic [CFG_W-1:0] RST_PAUSE_HOLD      = 16'd2500;
   localparam logic [CFG_W-1:0] RST_MENU_LONG_HOLD  = 16'd1000;
   localparam logic [CFG_W-1:0] RST_MENU_SETUP_HOLD = 16'd4000;

   typedef struct packed {
      logic [CFG_W-1:0] short_press_max_ms;
      logic [CFG_W-1:0] panic_hold_ms;
      logic [CFG_W-1:0] pause_hold_ms;
      logic [CFG_W-1:0] menu_long_hold_ms;
      logic [CFG_W-1:0] menu_setup_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [NOW_W-1:0] now_ms;
      logic             ok_pressed;
      logic             up_pressed;
      logic             down_pressed;
      logic             menu_pressed;
   } req_type;

   typedef struct packed {
      logic ok_short_event;
      logic panic_event;
      logic pause_event;
      logic up_short_event;
      logic down_short_event;
      logic menu_short_event;
      logic menu_long_event;
      logic menu_setup_event;
   } evt_type;

endpackage

`default_nettype wire

// ----- design/bpgd_if.sv -----
// Channel interfaces of the button press gesture decoder: tick input,
// event result and register write. Depend on bpgd_pkg for widths.
`default_nettype none

interface bpgd_req_if;
   logic                         valid;
   logic                         ready;
   logic [bpgd_pkg::NOW_W-1:0]   now_ms;
   logic                         ok_pressed;
   logic                         up_pressed;
   logic                         down_pressed;
   logic                         menu_pressed;

   modport source (output valid, now_ms, ok_pressed, up_pressed, down_pressed,
                   menu_pressed, input ready);
   modport sink   (input valid, now_ms, ok_pressed, up_pressed, down_pressed,
                   menu_pressed, output ready);
endinterface

interface bpgd_rsp_if;
   logic valid;
   logic ready;
   logic ok_short_event;
   logic panic_event;
   logic pause_event;
   logic up_short_event;
   logic down_short_event;
   logic menu_short_event;
   logic menu_long_event;
   logic menu_setup_event;

   modport source (output valid, ok_short_event, panic_event, pause_event,
                   up_short_event, down_short_event, menu_short_event,
                   menu_long_event, menu_setup_event, input ready);
   modport sink   (input valid, ok_short_event, panic_event, pause_event,
                   up_short_event, down_short_event, menu_short_event,
                   menu_long_event, menu_setup_event, output ready);
endinterface

interface bpgd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bpgd_pkg::CSR_IDX_W-1:0]   index;
   logic [bpgd_pkg::CFG_W-1:0]       wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ----- design/bpgd_csr.sv -----
// Threshold register file of the button press gesture decoder.
// Depends on bpgd_pkg and bpgd_csr_if.
`default_nettype none

module bpgd_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   bpgd_csr_if.sink           csr,
   output bpgd_pkg::cfg_type  cfg
);

   bpgd_pkg::cfg_type cfg_ff;
   bpgd_pkg::cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            bpgd_pkg::CSR_SHORT_PRESS_MAX: cfg_in.short_press_max_ms = csr.wdata;
            bpgd_pkg::CSR_PANIC_HOLD:      cfg_in.panic_hold_ms      = csr.wdata;
            bpgd_pkg::CSR_PAUSE_HOLD:      cfg_in.pause_hold_ms      = csr.wdata;
            bpgd_pkg::CSR_MENU_LONG_HOLD:  cfg_in.menu_long_hold_ms  = csr.wdata;
            bpgd_pkg::CSR_MENU_SETUP_HOLD: cfg_in.menu_setup_hold_ms = csr.wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_press_max_ms <= bpgd_pkg::RST_SHORT_PRESS_MAX;
         cfg_ff.panic_hold_ms      <= bpgd_pkg::RST_PANIC_HOLD;
         cfg_ff.pause_hold_ms      <= bpgd_pkg::RST_PAUSE_HOLD;
         cfg_ff.menu_long_hold_ms  <= bpgd_pkg::RST_MENU_LONG_HOLD;
         cfg_ff.menu_setup_hold_ms <= bpgd_pkg::RST_MENU_SETUP_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/bpgd_core.sv -----
// Per-button state and gesture decode of the button press gesture decoder.
// Depends on bpgd_pkg.
`default_nettype none

module bpgd_core #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  bpgd_pkg::req_type  item,
   input  bpgd_pkg::cfg_type  cfg,
   output bpgd_pkg::evt_type  evt
);

   typedef logic [TIME_WIDTH-1:0] tm_type;

   logic   ok_held_ff, ok_fired_ff, pause_fired_ff;
   logic   up_held_ff, up_fired_ff;
   logic   dn_held_ff, dn_fired_ff;
   logic   menu_held_ff, menu_fired_ff, setup_fired_ff;
   tm_type ok_time_ff, up_time_ff, dn_time_ff, menu_time_ff;

   logic   ok_held_in, ok_fired_in, pause_fired_in;
   logic   up_held_in, up_fired_in;
   logic   dn_held_in, dn_fired_in;
   logic   menu_held_in, menu_fired_in, setup_fired_in;
   tm_type ok_time_in, up_time_in, dn_time_in, menu_time_in;

   tm_type now_t, short_t;
   tm_type ok_t0, ok_el, up_el, dn_el, menu_t0, menu_el;
   logic   ok_press, ok_rel, ok_f0, ok_pf0, panic_hit, pause_hit, ok_stop;
   logic   up_press, up_rel, dn_press, dn_rel;
   logic   menu_press, menu_rel, menu_f0, menu_sf0, setup_hit, long_hit;

   assign now_t   = TIME_WIDTH'(item.now_ms);
   assign short_t = TIME_WIDTH'(cfg.short_press_max_ms);

   // ok button
   assign ok_press  = item.ok_pressed & ~ok_held_ff;
   assign ok_rel    = ~item.ok_pressed & ok_held_ff;
   assign ok_t0     = ok_press ? now_t : ok_time_ff;
   assign ok_f0     = ok_fired_ff & ~ok_press;
   assign ok_pf0    = pause_fired_ff & ~ok_press;
   assign ok_el     = now_t - ok_t0;
   assign panic_hit = item.ok_pressed & ~ok_f0 &
                      (ok_el >= TIME_WIDTH'(cfg.panic_hold_ms));
   assign pause_hit = item.ok_pressed & ~ok_pf0 &
                      (ok_el >= TIME_WIDTH'(cfg.pause_hold_ms));
   assign ok_stop   = ok_rel;

   assign ok_held_in     = item.ok_pressed;
   assign ok_time_in     = ok_t0;
   assign ok_fired_in    = ~ok_rel & (ok_f0 | panic_hit | pause_hit);
   assign pause_fired_in = ~ok_rel & (ok_pf0 | pause_hit);

   // up and down: short press only, skipped after an ok release
   assign up_press   = ~ok_stop & item.up_pressed & ~up_held_ff;
   assign up_rel     = ~ok_stop & ~item.up_pressed & up_held_ff;
   assign up_el      = now_t - up_time_ff;
   assign up_held_in = (up_press | up_rel) ? item.up_pressed : up_held_ff;
   assign up_time_in = up_press ? now_t : up_time_ff;
   assign up_fired_in = (up_press | up_rel) ? 1'b0 : up_fired_ff;

   assign dn_press   = ~ok_stop & item.down_pressed & ~dn_held_ff;
   assign dn_rel     = ~ok_stop & ~item.down_pressed & dn_held_ff;
   assign dn_el      = now_t - dn_time_ff;
   assign dn_held_in = (dn_press | dn_rel) ? item.down_pressed : dn_held_ff;
   assign dn_time_in = dn_press ? now_t : dn_time_ff;
   assign dn_fired_in = (dn_press | dn_rel) ? 1'b0 : dn_fired_ff;

   // menu: setup hold takes priority over the long hold
   assign menu_press = ~ok_stop & item.menu_pressed & ~menu_held_ff;
   assign menu_rel   = ~ok_stop & ~item.menu_pressed & menu_held_ff;
   assign menu_t0    = menu_press ? now_t : menu_time_ff;
   assign menu_f0    = menu_fired_ff & ~menu_press;
   assign menu_sf0   = setup_fired_ff & ~menu_press;
   assign menu_el    = now_t - menu_t0;
   assign setup_hit  = ~ok_stop & item.menu_pressed & ~menu_sf0 &
                       (menu_el >= TIME_WIDTH'(cfg.menu_setup_hold_ms));
   assign long_hit   = ~ok_stop & item.menu_pressed & ~setup_hit & ~menu_f0 &
                       (menu_el >= TIME_WIDTH'(cfg.menu_long_hold_ms));

   always_comb begin
      menu_held_in   = menu_held_ff;
      menu_time_in   = menu_time_ff;
      menu_fired_in  = menu_fired_ff;
      setup_fired_in = setup_fired_ff;
      if (!ok_stop) begin
         menu_held_in   = item.menu_pressed;
         menu_time_in   = menu_t0;
         menu_fired_in  = ~menu_rel & (menu_f0 | setup_hit | long_hit);
         setup_fired_in = ~menu_rel & (menu_sf0 | setup_hit);
      end
   end

   assign evt.ok_short_event   = ok_rel & ~ok_fired_ff & (ok_el < short_t);
   assign evt.panic_event      = panic_hit;
   assign evt.pause_event      = pause_hit;
   assign evt.up_short_event   = up_rel & ~up_fired_ff & (up_el < short_t);
   assign evt.down_short_event = dn_rel & ~dn_fired_ff & (dn_el < short_t);
   assign evt.menu_short_event = menu_rel & ~menu_fired_ff & (menu_el < short_t);
   assign evt.menu_long_event  = long_hit;
   assign evt.menu_setup_event = setup_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_held_ff     <= 1'b0;
         ok_fired_ff    <= 1'b0;
         pause_fired_ff <= 1'b0;
         ok_time_ff     <= '0;
         up_held_ff     <= 1'b0;
         up_fired_ff    <= 1'b0;
         up_time_ff     <= '0;
         dn_held_ff     <= 1'b0;
         dn_fired_ff    <= 1'b0;
         dn_time_ff     <= '0;
         menu_held_ff   <= 1'b0;
         menu_fired_ff  <= 1'b0;
         setup_fired_ff <= 1'b0;
         menu_time_ff   <= '0;
      end else if (step) begin
         ok_held_ff     <= ok_held_in;
         ok_fired_ff    <= ok_fired_in;
         pause_fired_ff <= pause_fired_in;
         ok_time_ff     <= ok_time_in;
         up_held_ff     <= up_held_in;
         up_fired_ff    <= up_fired_in;
         up_time_ff     <= up_time_in;
         dn_held_ff     <= dn_held_in;
         dn_fired_ff    <= dn_fired_in;
         dn_time_ff     <= dn_time_in;
         menu_held_ff   <= menu_held_in;
         menu_fired_ff  <= menu_fired_in;
         setup_fired_ff <= setup_fired_in;
         menu_time_ff   <= menu_time_in;
      end
   end

   a_pause_implies_ok_fired : assert property (@(posedge clock) disable iff (reset)
      pause_fired_ff |-> ok_fired_ff)
      else $error("pause fired without ok fired");

   a_setup_implies_menu_fired : assert property (@(posedge clock) disable iff (reset)
      setup_fired_ff |-> menu_fired_ff)
      else $error("setup fired without menu fired");

   a_setup_excludes_long : assert property (@(posedge clock) disable iff (reset)
      step |-> !(evt.menu_setup_event && evt.menu_long_event))
      else $error("setup and long hold on one transaction");

   a_ok_release_ends_tick : assert property (@(posedge clock) disable iff (reset)
      step && ok_held_ff && !item.ok_pressed |=>
         $stable(up_held_ff) && $stable(dn_held_ff) && $stable(menu_held_ff)
         && $stable(menu_fired_ff) && !ok_held_ff)
      else $error("buttons after an ok release were updated");

endmodule

`default_nettype wire

// ----- design/button_press_gesture_decoder.sv -----
// Button press gesture decoder: one tick of four button levels in, one word
// of eight gesture event flags out. Rate: one transaction accepted every
// clock cycle while rsp_chan is not stalling. A tick goes into the input
// register; a single registered pass then updates the per-button state
// and loads the result register. req_chan.ready
// follows rsp_chan.ready combinationally when both registers are full.
// Threshold registers are written on csr_chan at any time (ready always high)
// and must change only while no tick is in flight.
// Depends on bpgd_pkg, the channel interfaces, bpgd_csr and bpgd_core.
`default_nettype none

module button_press_gesture_decoder #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   bpgd_req_if.sink     req_chan,
   bpgd_rsp_if.source   rsp_chan,
   bpgd_csr_if.sink     csr_chan
);

   bpgd_pkg::cfg_type cfg;
   bpgd_pkg::evt_type evt;

   logic              in_valid_ff, in_valid_in;
   bpgd_pkg::req_type in_item_ff;
   logic              out_valid_ff, out_valid_in;
   bpgd_pkg::evt_type out_evt_ff;
   logic              step, accept;

   assign step   = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign accept = req_chan.valid & req_chan.ready;

   assign req_chan.ready = ~in_valid_ff | step;
   assign in_valid_in    = accept | (in_valid_ff & ~step);
   assign out_valid_in   = step | (out_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.now_ms       <= req_chan.now_ms;
         in_item_ff.ok_pressed   <= req_chan.ok_pressed;
         in_item_ff.up_pressed   <= req_chan.up_pressed;
         in_item_ff.down_pressed <= req_chan.down_pressed;
         in_item_ff.menu_pressed <= req_chan.menu_pressed;
      end
      if (step) begin
         out_evt_ff <= evt;
      end
   end

   bpgd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   bpgd_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .cfg   (cfg),
      .evt   (evt)
   );

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.ok_short_event   = out_evt_ff.ok_short_event;
   assign rsp_chan.panic_event      = out_evt_ff.panic_event;
   assign rsp_chan.pause_event      = out_evt_ff.pause_event;
   assign rsp_chan.up_short_event   = out_evt_ff.up_short_event;
   assign rsp_chan.down_short_event = out_evt_ff.down_short_event;
   assign rsp_chan.menu_short_event = out_evt_ff.menu_short_event;
   assign rsp_chan.menu_long_event  = out_evt_ff.menu_long_event;
   assign rsp_chan.menu_setup_event = out_evt_ff.menu_setup_event;

   a_step_fills_output : assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed transaction did not reach the result register");

   a_no_step_when_blocked : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !step)
      else $error("result register overwritten while stalled");

   a_accept_loads_input : assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted transaction lost from the input register");

endmodule

`default_nettype wire

// ----- tb/sv/tb_button_press_gesture_decoder.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for button_press_gesture_decoder: directed ticks, then random
// button sequences under several threshold settings and handshake pacing modes.
// Depends on bpgd_pkg, the channel interfaces in bpgd_if.sv and button_press_gesture_decoder.

module tb_button_press_gesture_decoder;
   import bpgd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      logic             held;
      logic [NOW_W-1:0] pressed_at;
      logic             fired;
   } button_track_type;

   typedef struct packed {
      req_type tick;
      logic    fixed;
      evt_type want;
      logic    zero_thr;
   } tick_row_type;

   // event bits, MSB first: ok_short panic pause up_short down_short menu_short long setup
   localparam tick_row_type DIRECTED_TICKS [0:23] = '{
      '{'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0000_0000, 1'b0},
      '{'{32'h0000_0064, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0000_0000, 1'b0},
      '{'{32'h0000_044C, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0100_0000, 1'b0},
      '{'{32'h0000_0A28, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0010_0000, 1'b0},
      '{'{32'h0000_0A8C, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0000_0000, 1'b0},
      '{'{32'h0000_0BB8, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 8'b0000_0000, 1'b0},
      '{'{32'h0000_0C1C, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b1000_0000, 1'b0},
      '{'{32'h0000_0C80, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0001_1100, 1'b0},
      '{'{32'h0000_0FA0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, 8'b0000_0000, 1'b0},
      '{'{32'h0000_1388, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, 8'b0000_0010, 1'b0},
      '{'{32'h0000_1F40, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, 8'b0000_0001, 1'b0},
      '{'{32'h0000_1FA4, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0001_0000, 1'b0},
      '{'{32'h0000_2328, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, 8'b0000_0000, 1'b0},
      '{'{32'h0000_2EE0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0110_0000, 1'b0},
      '{'{32'h0000_2EE1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0000_0000, 1'b0},
      '{'{32'hFFFF_FF00, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, 8'b0000_0000, 1'b0},
      '{'{32'h0000_0100, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0000_1000, 1'b0},
      '{'{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 8'b0000_0000, 1'b0},
      '{'{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, 8'b1000_0000, 1'b0},
      '{'{32'h0000_031F, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0000_0000, 1'b0},
      '{'{32'h0000_0032, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b1, 8'b0110_0001, 1'b1},
      '{'{32'h0000_003C, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0000_0000, 1'b0},
      '{'{32'h0000_0046, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, 8'b0000_0000, 1'b0},
      '{'{32'h0000_0046, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'b0000_0000, 1'b0}
   };

   logic clock;
   logic reset;

   bpgd_req_if req_chan ();
   bpgd_rsp_if rsp_chan ();
   bpgd_csr_if csr_chan ();

   button_press_gesture_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   button_track_type ok_trk, up_trk, dn_trk, menu_trk;
   logic          pause_done, setup_done;
   cfg_type       thr;

   evt_type    expected_events [$];
   int         errors        = 0;
   int         ticks_sent    = 0;
   int         words_checked = 0;
   int         cycles        = 0;
   int         send_idle_pct = 0;
   int         stall_pct     = 0;
   int         evt_seen [8];
   logic [NOW_W-1:0] sim_ms;
   logic [3:0]       btn_levels;
   string      event_name [8] = '{"menu_setup", "menu_long", "menu_short", "down_short",
                                  "up_short", "pause", "panic", "ok_short"};

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [NOW_W-1:0] held_for(logic [NOW_W-1:0] now,
                                                 logic [NOW_W-1:0] since);
      return now - since;
   endfunction

   function automatic logic short_release(logic lvl, logic [NOW_W-1:0] now,
                                          inout button_track_type b);
      logic hit;
      hit = 1'b0;
      if (lvl && !b.held) begin
         b.held       = 1'b1;
         b.pressed_at = now;
         b.fired      = 1'b0;
      end
      if (!lvl && b.held) begin
         hit     = !b.fired && (held_for(now, b.pressed_at) < thr.short_press_max_ms);
         b.held  = 1'b0;
         b.fired = 1'b0;
      end
      return hit;
   endfunction

   function automatic evt_type decode_tick(req_type t);
      evt_type          ev;
      logic [NOW_W-1:0] span;
      ev = '0;
      if (t.ok_pressed && !ok_trk.held) begin
         ok_trk     = '{1'b1, t.now_ms, 1'b0};
         pause_done = 1'b0;
      end
      if (!t.ok_pressed && ok_trk.held) begin
         ev.ok_short_event = !ok_trk.fired &&
                             (held_for(t.now_ms, ok_trk.pressed_at) < thr.short_press_max_ms);
         ok_trk.held  = 1'b0;
         ok_trk.fired = 1'b0;
         pause_done   = 1'b0;
         return ev;
      end
      if (t.ok_pressed && ok_trk.held) begin
         span = held_for(t.now_ms, ok_trk.pressed_at);
         if (span >= thr.panic_hold_ms && !ok_trk.fired) begin
            ok_trk.fired   = 1'b1;
            ev.panic_event = 1'b1;
         end
         if (span >= thr.pause_hold_ms && !pause_done) begin
            pause_done     = 1'b1;
            ok_trk.fired   = 1'b1;
            ev.pause_event = 1'b1;
         end
      end
      ev.up_short_event   = short_release(t.up_pressed, t.now_ms, up_trk);
      ev.down_short_event = short_release(t.down_pressed, t.now_ms, dn_trk);
      if (t.menu_pressed && !menu_trk.held) begin
         menu_trk   = '{1'b1, t.now_ms, 1'b0};
         setup_done = 1'b0;
      end
      if (!t.menu_pressed && menu_trk.held) begin
         ev.menu_short_event = !menu_trk.fired &&
                               (held_for(t.now_ms, menu_trk.pressed_at) < thr.short_press_max_ms);
         menu_trk.held  = 1'b0;
         menu_trk.fired = 1'b0;
         setup_done     = 1'b0;
         return ev;
      end
      if (t.menu_pressed && menu_trk.held) begin
         span = held_for(t.now_ms, menu_trk.pressed_at);
         if (span >= thr.menu_setup_hold_ms && !setup_done) begin
            setup_done          = 1'b1;
            menu_trk.fired      = 1'b1;
            ev.menu_setup_event = 1'b1;
            return ev;
         end
         if (span >= thr.menu_long_hold_ms && !menu_trk.fired) begin
            menu_trk.fired     = 1'b1;
            ev.menu_long_event = 1'b1;
         end
      end
      return ev;
   endfunction

   task automatic send_tick(req_type t, logic fixed, evt_type want);
      evt_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.now_ms       <= t.now_ms;
      req_chan.ok_pressed   <= t.ok_pressed;
      req_chan.up_pressed   <= t.up_pressed;
      req_chan.down_pressed <= t.down_pressed;
      req_chan.menu_pressed <= t.menu_pressed;
      do @(posedge clock); while (!req_chan.ready);
      predicted = decode_tick(t);
      expected_events.push_back(fixed ? want : predicted);
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_SHORT_PRESS_MAX: thr.short_press_max_ms = val;
         CSR_PANIC_HOLD:      thr.panic_hold_ms      = val;
         CSR_PAUSE_HOLD:      thr.pause_hold_ms      = val;
         CSR_MENU_LONG_HOLD:  thr.menu_long_hold_ms  = val;
         CSR_MENU_SETUP_HOLD: thr.menu_setup_hold_ms = val;
         default: ;
      endcase
   endtask

   task automatic program_thresholds(cfg_type c);
      wait_drained();
      write_threshold(CSR_SHORT_PRESS_MAX, c.short_press_max_ms);
      write_threshold(CSR_PANIC_HOLD, c.panic_hold_ms);
      write_threshold(CSR_PAUSE_HOLD, c.pause_hold_ms);
      write_threshold(CSR_MENU_LONG_HOLD, c.menu_long_hold_ms);
      write_threshold(CSR_MENU_SETUP_HOLD, c.menu_setup_hold_ms);
      // unmapped index: must leave every threshold alone
      write_threshold(CSR_MENU_SETUP_HOLD + CSR_IDX_W'($urandom_range(3, 1)),
                      CFG_W'($urandom));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_random(int n, int idle_pct, int stall, logic hold_midway);
      req_type t;
      int      r;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int k = 0; k < n; k++) begin
         if (hold_midway && k == n / 2)
            wait_drained();
         r = $urandom_range(99);
         if (r < 5) begin
            t.now_ms = $urandom;
            {t.ok_pressed, t.up_pressed, t.down_pressed, t.menu_pressed} = 4'($urandom);
         end else begin
            r = $urandom_range(99);
            if (r < 40)
               sim_ms += $urandom_range(60);
            else if (r < 85)
               sim_ms += $urandom_range(1500);
            else if (r < 97)
               sim_ms += $urandom_range(5000, 1000);
            else
               sim_ms += $urandom_range(80000);
            for (int b = 0; b < 4; b++)
               if ($urandom_range(99) < 25)
                  btn_levels[b] = ~btn_levels[b];
            t.now_ms = sim_ms;
            {t.ok_pressed, t.up_pressed, t.down_pressed, t.menu_pressed} = btn_levels;
         end
         send_tick(t, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : event_check
      evt_type got, want;
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.ok_short_event, rsp_chan.panic_event, rsp_chan.pause_event,
                rsp_chan.up_short_event, rsp_chan.down_short_event,
                rsp_chan.menu_short_event, rsp_chan.menu_long_event,
                rsp_chan.menu_setup_event};
         for (int i = 0; i < 8; i++)
            if (got[i] === 1'b1)
               evt_seen[i]++;
         if (expected_events.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("event word %b with no tick outstanding", got);
         end else begin
            want = expected_events.pop_front();
            for (int i = 7; i >= 0; i--) begin
               if (got[i] !== want[i]) begin
                  errors++;
                  if (errors <= REPORT_MAX)
                     $display("word %0d %s: expected %b, got %b",
                              words_checked, event_name[i], want[i], got[i]);
               end
            end
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      thr        = '{RST_SHORT_PRESS_MAX, RST_PANIC_HOLD, RST_PAUSE_HOLD,
                     RST_MENU_LONG_HOLD, RST_MENU_SETUP_HOLD};
      ok_trk     = '{1'b0, '0, 1'b0};
      up_trk     = '{1'b0, '0, 1'b0};
      dn_trk     = '{1'b0, '0, 1'b0};
      menu_trk   = '{1'b0, '0, 1'b0};
      pause_done = 1'b0;
      setup_done = 1'b0;
      sim_ms     = $urandom;
      btn_levels = '0;
      foreach (evt_seen[i])
         evt_seen[i] = 0;

      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.now_ms       = '0;
      req_chan.ok_pressed   = 1'b0;
      req_chan.up_pressed   = 1'b0;
      req_chan.down_pressed = 1'b0;
      req_chan.menu_pressed = 1'b0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = '0;
      csr_chan.wdata        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_TICKS[i]) begin
         if (DIRECTED_TICKS[i].zero_thr)
            program_thresholds('0);
         send_tick(DIRECTED_TICKS[i].tick, DIRECTED_TICKS[i].fixed, DIRECTED_TICKS[i].want);
      end

      program_thresholds('{RST_SHORT_PRESS_MAX, RST_PANIC_HOLD, RST_PAUSE_HOLD,
                           RST_MENU_LONG_HOLD, RST_MENU_SETUP_HOLD});
      run_random(130, 0, 0, 1'b0);
      program_thresholds('{CFG_W'($urandom_range(3000)), CFG_W'($urandom_range(3000)),
                           CFG_W'($urandom_range(3000)), CFG_W'($urandom_range(3000)),
                           CFG_W'($urandom_range(3000))});
      run_random(130, 87, 0, 1'b1);
      program_thresholds('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      run_random(130, 0, 87, 1'b0);
      program_thresholds('{CFG_W'($urandom_range(400)), CFG_W'($urandom_range(400)),
                           CFG_W'($urandom_range(400)), CFG_W'($urandom_range(400)),
                           CFG_W'($urandom_range(400))});
      run_random(130, 36, 36, 1'b0);
      program_thresholds('{CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                           CFG_W'($urandom), CFG_W'($urandom)});
      run_random(130, 0, 0, 1'b0);

      wait_drained();
      errors += expected_events.size();

      $display("%0d ticks over seven threshold settings and four pacing modes, %0d words checked",
               ticks_sent, words_checked);
      $display("events: ok_short %0d panic %0d pause %0d up %0d down %0d",
               evt_seen[7], evt_seen[6], evt_seen[5], evt_seen[4], evt_seen[3]);
      $display("        menu %0d long %0d setup %0d",
               evt_seen[2], evt_seen[1], evt_seen[0]);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
design/bpgd_pkg.sv
design/bpgd_if.sv
design/bpgd_csr.sv
design/bpgd_core.sv
design/button_press_gesture_decoder.sv
tb/sv/tb_button_press_gesture_decoder.sv
